/* hw/rtl/cmdm_pkg.sv */
// Shared constants, command tables and the result type of the command line matcher.
// No dependencies; used by cmdm_line_core, the top level and the checker.

package cmdm_pkg;

    // Line length limit and derived counter width (counter saturates at MAX_LINE).
    localparam int MAX_LINE   = 256;
    localparam int LINE_POS_W = $clog2(MAX_LINE + 1);

    // Argument number format.
    localparam int MANT_W = 32;
    localparam int FRAC_W = 8;
    localparam int CODE_W = 3;

    // Stream widths: tdata holds the result fields packed from bit 0, padded to bytes.
    localparam int S_TDATA_W   = 8;
    localparam int RESULT_W    = CODE_W + 1 + MANT_W + FRAC_W + 1;
    localparam int M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

    // Command codes.
    localparam logic [CODE_W-1:0] CODE_VERSION    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_LED_ON     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_LED_OFF    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_GET_LED    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_SERVO_SET  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_SERVO_READ = 3'd5;
    localparam logic [CODE_W-1:0] CODE_INVALID    = 3'd6;

    // Exact-match command table, indexed by entry and character position.
    localparam int NUM_EXACT  = 5;
    localparam int CMD_IDX_W  = 4;
    localparam int CMD_DEPTH  = 1 << CMD_IDX_W;
    localparam int PREFIX_LEN = 10;

    localparam int EXACT_LEN [NUM_EXACT] = '{14, 13, 14, 14, 12};

    localparam logic [CODE_W-1:0] EXACT_CODE [NUM_EXACT] = '{
        CODE_VERSION, CODE_LED_ON, CODE_LED_OFF, CODE_GET_LED, CODE_SERVO_READ
    };

    localparam logic [7:0] CMD_TEXT [NUM_EXACT][CMD_DEPTH] = '{
        '{"s", "t", "m", " ", "-", "-", "v", "e", "r", "s", "i", "o", "n", 8'h0D,
          8'h00, 8'h00},
        '{"s", "t", "m", " ", "l", "e", "d", " ", "-", "-", "o", "n", 8'h0D, 8'h00,
          8'h00, 8'h00},
        '{"s", "t", "m", " ", "l", "e", "d", " ", "-", "-", "o", "f", "f", 8'h0D,
          8'h00, 8'h00},
        '{"s", "t", "m", " ", "g", "e", "t", " ", "-", "-", "l", "e", "d", 8'h0D,
          8'h00, 8'h00},
        '{"s", "t", "m", " ", "-", "-", "s", "e", "r", "v", "o", 8'h0D, 8'h00, 8'h00,
          8'h00, 8'h00}
    };

    localparam logic [7:0] PREFIX_TEXT [CMD_DEPTH] = '{
        "s", "t", "m", " ", "s", "e", "r", "v", "o", "=",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // One result item plus the flag saying the current byte closes the line.
    typedef struct packed {
        logic              line_end;
        logic [CODE_W-1:0] command_code;
        logic              arg_negative;
        logic [MANT_W-1:0] arg_mantissa;
        logic [FRAC_W-1:0] arg_frac_digits;
        logic              arg_saturated;
    } cmdm_result_t;

endpackage

/* hw/rtl/cmdm_line_core.sv */
// Per-byte line state of the command line matcher: match flags, argument parser
// and result decode. Depends on cmdm_pkg.

module cmdm_line_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   byte_en,
    input  logic [7:0]             byte_in,
    output cmdm_pkg::cmdm_result_t result
);

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_INT  = 3'd2;
    localparam logic [2:0] PH_FRAC = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    localparam int SUM_W = cmdm_pkg::MANT_W + 4;
    localparam logic [cmdm_pkg::LINE_POS_W-1:0] POS_LIMIT =
        cmdm_pkg::LINE_POS_W'(cmdm_pkg::MAX_LINE);
    localparam logic [cmdm_pkg::FRAC_W-1:0] FRAC_MAX = '1;

    logic [cmdm_pkg::LINE_POS_W-1:0] pos_reg, pos_next;
    logic [cmdm_pkg::NUM_EXACT-1:0]  exact_reg, exact_next;
    logic                            prefix_reg, prefix_next;
    logic [2:0]                      phase_reg, phase_next;
    logic [cmdm_pkg::MANT_W-1:0]     mant_reg, mant_next;
    logic [cmdm_pkg::FRAC_W-1:0]     frac_reg, frac_next;
    logic                            neg_reg, neg_next;
    logic                            ovf_reg, ovf_next;
    logic                            ret_reg, ret_next;

    logic [7:0]                      lc;
    logic                            is_digit;
    logic [SUM_W-1:0]                mant_sum;
    logic                            mant_ovf;
    logic [2:0]                      phase_work;
    logic                            consumed;
    logic                            found;
    logic [cmdm_pkg::CMD_IDX_W-1:0]  tbl_idx;

    // Fold A-Z to lower case; digits keep their value in the low nibble.
    assign lc       = (byte_in >= CH_UPA && byte_in <= CH_UPZ) ? byte_in + CASE_OFS : byte_in;
    assign is_digit = (lc >= CH_0) && (lc <= CH_9);
    assign tbl_idx  = pos_reg[cmdm_pkg::CMD_IDX_W-1:0];

    // mantissa * 10 + digit, with the carry bits showing overflow.
    assign mant_sum = {1'b0, mant_reg, 3'b000} + {3'b000, mant_reg, 1'b0}
                    + {{(SUM_W-4){1'b0}}, lc[3:0]};
    assign mant_ovf = |mant_sum[SUM_W-1:cmdm_pkg::MANT_W];

    always_comb begin
        pos_next    = pos_reg;
        exact_next  = exact_reg;
        prefix_next = prefix_reg;
        phase_next  = phase_reg;
        mant_next   = mant_reg;
        frac_next   = frac_reg;
        neg_next    = neg_reg;
        ovf_next    = ovf_reg;
        ret_next    = ret_reg;
        phase_work  = phase_reg;
        consumed    = 1'b0;

        if (byte_en) begin
            if (byte_in == CH_LF) begin
                pos_next    = '0;
                exact_next  = '1;
                prefix_next = 1'b1;
                phase_next  = PH_WAIT;
                mant_next   = '0;
                frac_next   = '0;
                neg_next    = 1'b0;
                ovf_next    = 1'b0;
                ret_next    = 1'b0;
            end else if (pos_reg < POS_LIMIT) begin
                for (int i = 0; i < cmdm_pkg::NUM_EXACT; i++) begin
                    if (pos_reg >= cmdm_pkg::LINE_POS_W'(cmdm_pkg::EXACT_LEN[i]) ||
                        lc != cmdm_pkg::CMD_TEXT[i][tbl_idx]) begin
                        exact_next[i] = 1'b0;
                    end
                end

                if (pos_reg < cmdm_pkg::LINE_POS_W'(cmdm_pkg::PREFIX_LEN)) begin
                    prefix_next = prefix_reg && (lc == cmdm_pkg::PREFIX_TEXT[tbl_idx]);
                    if (pos_reg == cmdm_pkg::LINE_POS_W'(cmdm_pkg::PREFIX_LEN - 1) &&
                        prefix_next) begin
                        phase_next = PH_SIGN;
                    end
                end else if (phase_reg >= PH_SIGN && phase_reg <= PH_SKIP) begin
                    if (lc == CH_CR) begin
                        ret_next   = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        // A sign is allowed only as the first argument character.
                        if (phase_work == PH_SIGN) begin
                            phase_work = PH_INT;
                            if (lc == CH_MINUS) begin
                                neg_next = 1'b1;
                                consumed = 1'b1;
                            end else if (lc == CH_PLUS) begin
                                consumed = 1'b1;
                            end
                        end
                        if (!consumed) begin
                            if (phase_work == PH_INT) begin
                                if (lc == CH_DOT) begin
                                    phase_work = PH_FRAC;
                                end else if (is_digit) begin
                                    if (mant_ovf) begin
                                        mant_next = '1;
                                        ovf_next  = 1'b1;
                                    end else begin
                                        mant_next = mant_sum[cmdm_pkg::MANT_W-1:0];
                                    end
                                end else begin
                                    phase_work = PH_SKIP;
                                end
                            end else if (phase_work == PH_FRAC) begin
                                if (is_digit) begin
                                    if (mant_ovf) begin
                                        mant_next = '1;
                                        ovf_next  = 1'b1;
                                    end else begin
                                        mant_next = mant_sum[cmdm_pkg::MANT_W-1:0];
                                    end
                                    if (frac_reg == FRAC_MAX) begin
                                        ovf_next = 1'b1;
                                    end else begin
                                        frac_next = frac_reg + 1'b1;
                                    end
                                end else begin
                                    phase_work = PH_SKIP;
                                end
                            end
                        end
                        phase_next = phase_work;
                    end
                end
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Result decode: first matching entry wins, the prefix command sits between
    // the fourth and fifth exact entries.
    always_comb begin
        result                 = '0;
        result.line_end        = (byte_in == CH_LF);
        result.command_code    = cmdm_pkg::CODE_INVALID;
        found                  = 1'b0;
        if (pos_reg < POS_LIMIT) begin
            for (int i = 0; i < cmdm_pkg::NUM_EXACT; i++) begin
                if (!found) begin
                    if (i == cmdm_pkg::NUM_EXACT - 1 && prefix_reg && ret_reg) begin
                        found                  = 1'b1;
                        result.command_code    = cmdm_pkg::CODE_SERVO_SET;
                        result.arg_negative    = neg_reg;
                        result.arg_mantissa    = mant_reg;
                        result.arg_frac_digits = frac_reg;
                        result.arg_saturated   = ovf_reg;
                    end else if (exact_reg[i] &&
                                 pos_reg == cmdm_pkg::LINE_POS_W'(cmdm_pkg::EXACT_LEN[i])) begin
                        found               = 1'b1;
                        result.command_code = cmdm_pkg::EXACT_CODE[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            exact_reg  <= '1;
            prefix_reg <= 1'b1;
            phase_reg  <= PH_WAIT;
            mant_reg   <= '0;
            frac_reg   <= '0;
            neg_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            ret_reg    <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            exact_reg  <= exact_next;
            prefix_reg <= prefix_next;
            phase_reg  <= phase_next;
            mant_reg   <= mant_next;
            frac_reg   <= frac_next;
            neg_reg    <= neg_next;
            ovf_reg    <= ovf_next;
            ret_reg    <= ret_next;
        end
    end

endmodule

/* hw/rtl/uart_command_line_matcher_top.sv */
// Top level of the command line matcher: input item register, result register
// and stream handshakes. Depends on cmdm_pkg and cmdm_line_core.

// Takes one received byte per item and gives one result item for each line
// feed: the command code and, for the servo set command, the parsed argument.
// The block accepts a byte in every cycle unless a line feed is held. A byte
// goes into an input register and, unless held, is matched and accumulated
// in the following cycle; a line feed then writes the result register, which
// drives m_tvalid. Only a line feed that meets a full result register
// still waiting for m_tready holds the input, for as long as m_tready stays low;
// other bytes pass on. No clearing pass is needed after reset.

module uart_command_line_matcher_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cmdm_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] command_code, [3] arg_negative, [35:4] arg_mantissa,
    // [43:36] arg_frac_digits, [44] arg_saturated, [47:45] zero
    output logic [cmdm_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                            in_valid_reg, in_valid_next;
    logic [7:0]                      in_byte_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [cmdm_pkg::M_TDATA_W-1:0]  out_data_reg;
    logic                            fire;
    cmdm_pkg::cmdm_result_t          res;

    cmdm_line_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (fire),
        .byte_in (in_byte_reg),
        .result  (res)
    );

    // A held byte moves on unless it closes a line and the result slot is busy.
    assign fire     = in_valid_reg && (!res.line_end || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire && res.line_end) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (fire && res.line_end) begin
            out_data_reg <= {{(cmdm_pkg::M_TDATA_W - cmdm_pkg::RESULT_W){1'b0}},
                             res.arg_saturated, res.arg_frac_digits, res.arg_mantissa,
                             res.arg_negative, res.command_code};
        end
    end

endmodule

/* hw/rtl/cmdm_checker.sv */
// Port-level checks for the command line matcher top level, with its bind.
// Depends on cmdm_pkg and uart_command_line_matcher_top.

module cmdm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [cmdm_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cmdm_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int PAD_W = cmdm_pkg::M_TDATA_W - cmdm_pkg::RESULT_W;

    // A reset cycle leaves no result item pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result item holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // Codes stay within the command set and the padding stays zero.
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[cmdm_pkg::CODE_W-1:0] <= cmdm_pkg::CODE_INVALID &&
                     m_tdata[cmdm_pkg::M_TDATA_W-1 -: PAD_W] == '0)
        else $error("bad command code or padding");

    // Argument fields are zero for every command except servo set.
    a_arg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[cmdm_pkg::CODE_W-1:0] != cmdm_pkg::CODE_SERVO_SET |->
        m_tdata[cmdm_pkg::RESULT_W-1:cmdm_pkg::CODE_W] == '0)
        else $error("argument fields set on a command without argument");

endmodule

bind uart_command_line_matcher_top cmdm_checker u_cmdm_checker (.*);

/* tb/cmdm_reply_checker.sv */
`timescale 1ns / 1ps
// Watches both streams of the command line matcher, tracks each line as it is received
// and checks every result item against the command it should decode to.
// Depends on cmdm_pkg for widths and command codes.

module cmdm_reply_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [cmdm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [cmdm_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             error_count,
    output int                             replies_due
);
    import cmdm_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              negative;
        logic [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0] frac_digits;
        logic              saturated;
    } reply_t;

    typedef enum logic [2:0] {
        ARG_WAIT, ARG_SIGN, ARG_INT, ARG_FRAC, ARG_SKIP, ARG_DONE
    } arg_phase_t;

    localparam logic [7:0]  CH_LF = 8'h0A;
    localparam logic [7:0]  CH_CR = 8'h0D;
    localparam logic [63:0] MANT_LIMIT = (64'd1 << MANT_W) - 64'd1;
    // The servo set command is tried just before the table entry for servo read.
    localparam int SERVO_READ_SLOT = 4;

    localparam logic [CODE_W-1:0] WORD_CODE [NUM_EXACT] = '{
        CODE_VERSION, CODE_LED_ON, CODE_LED_OFF, CODE_GET_LED, CODE_SERVO_READ
    };

    // Exact commands without their closing carriage return.
    string cmd_word [NUM_EXACT] = '{
        "stm --version", "stm led --on", "stm led --off", "stm get --led", "stm --servo"
    };
    string servo_prefix = "stm servo=";

    int                   line_len;
    logic [NUM_EXACT-1:0] word_alive;
    logic                 prefix_alive;
    arg_phase_t           phase;
    logic [63:0]          mant_acc;
    int                   frac_cnt;
    logic                 neg_seen;
    logic                 clamp_seen;
    logic                 cr_seen;
    reply_t               replies_q [$];

    task clear_line();
        line_len     = 0;
        word_alive   = '1;
        prefix_alive = 1'b1;
        phase        = ARG_WAIT;
        mant_acc     = '0;
        frac_cnt     = 0;
        neg_seen     = 1'b0;
        clamp_seen   = 1'b0;
        cr_seen      = 1'b0;
    endtask

    task take_digit(input logic [7:0] ch);
        logic [63:0] d;
        d = 64'(ch - 8'h30);
        if (mant_acc > (MANT_LIMIT - d) / 64'd10) begin
            mant_acc   = MANT_LIMIT;
            clamp_seen = 1'b1;
        end else begin
            mant_acc = mant_acc * 64'd10 + d;
        end
    endtask

    task parse_arg(input logic [7:0] c);
        logic is_digit;
        is_digit = (c >= "0" && c <= "9");
        if (phase == ARG_SIGN) begin
            phase = ARG_INT;
            if (c == "-") begin
                neg_seen = 1'b1;
                return;
            end
            if (c == "+") return;
        end
        if (phase == ARG_INT) begin
            if (c == ".") phase = ARG_FRAC;
            else if (is_digit) take_digit(c);
            else phase = ARG_SKIP;
        end else if (phase == ARG_FRAC) begin
            if (is_digit) begin
                take_digit(c);
                if (frac_cnt >= 255) clamp_seen = 1'b1;
                else frac_cnt++;
            end else begin
                phase = ARG_SKIP;
            end
        end
    endtask

    task fold_line_byte(input logic [7:0] raw);
        logic [7:0] c;
        logic [7:0] want;
        reply_t     r;
        int         n;
        c = raw;
        if (c != CH_LF) begin
            // Bytes past the length limit leave the line untouched.
            if (line_len >= MAX_LINE) return;
            if (c >= "A" && c <= "Z") c = c + 8'd32;
            for (int i = 0; i < NUM_EXACT; i++) begin
                n    = cmd_word[i].len();
                want = (line_len < n) ? cmd_word[i][line_len] : CH_CR;
                if (line_len > n || c != want) word_alive[i] = 1'b0;
            end
            if (line_len < servo_prefix.len()) begin
                if (c != servo_prefix[line_len]) prefix_alive = 1'b0;
                if (line_len == servo_prefix.len() - 1 && prefix_alive) phase = ARG_SIGN;
            end else if (phase >= ARG_SIGN && phase <= ARG_SKIP) begin
                if (c == CH_CR) begin
                    cr_seen = 1'b1;
                    phase   = ARG_DONE;
                end else begin
                    parse_arg(c);
                end
            end
            line_len++;
            return;
        end
        r      = '0;
        r.code = CODE_INVALID;
        if (line_len < MAX_LINE) begin
            for (int i = 0; i < NUM_EXACT; i++) begin
                if (i == SERVO_READ_SLOT && prefix_alive && cr_seen) begin
                    r.code        = CODE_SERVO_SET;
                    r.negative    = neg_seen;
                    r.mantissa    = mant_acc[MANT_W-1:0];
                    r.frac_digits = FRAC_W'(frac_cnt);
                    r.saturated   = clamp_seen;
                    break;
                end
                if (word_alive[i] && line_len == cmd_word[i].len() + 1) begin
                    r.code = WORD_CODE[i];
                    break;
                end
            end
        end
        replies_q.push_back(r);
        clear_line();
    endtask

    task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            clear_line();
            replies_q.delete();
            error_count = 0;
        end else begin
            // The result side goes first so a new line feed cannot absorb a stray item.
            if (m_tvalid && m_tready) begin
                got.code        = m_tdata[CODE_W-1:0];
                got.negative    = m_tdata[CODE_W];
                got.mantissa    = m_tdata[CODE_W+1 +: MANT_W];
                got.frac_digits = m_tdata[CODE_W+1+MANT_W +: FRAC_W];
                got.saturated   = m_tdata[CODE_W+1+MANT_W+FRAC_W];
                if (replies_q.size() == 0) begin
                    $error("result item with no line pending: command_code %0d", got.code);
                    error_count++;
                end else begin
                    want = replies_q.pop_front();
                    check_field("command_code", want.code, got.code);
                    check_field("arg_negative", want.negative, got.negative);
                    check_field("arg_mantissa", want.mantissa, got.mantissa);
                    check_field("arg_frac_digits", want.frac_digits, got.frac_digits);
                    check_field("arg_saturated", want.saturated, got.saturated);
                    check_field("padding", 64'd0, 64'(m_tdata[M_TDATA_W-1:RESULT_W]));
                end
            end
            if (s_tvalid && s_tready) fold_line_byte(s_tdata);
        end
        replies_due = replies_q.size();
    end

endmodule

/* tb/tb_uart_command_line_matcher_top.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the command line matcher: directed command lines, then
// random lines with idle input cycles and result stalls. Depends on cmdm_pkg,
// uart_command_line_matcher_top and cmdm_reply_checker.

module tb_uart_command_line_matcher_top;
    import cmdm_pkg::*;

    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam int         RANDOM_BYTES = 330;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;

    int         error_count;
    int         replies_due;
    bit         steady     = 1'b0;
    int         bytes_sent = 0;
    logic [7:0] line_q [$];

    string command_word [NUM_EXACT] = '{
        "stm --version", "stm led --on", "stm led --off", "stm get --led", "stm --servo"
    };

    always #5 aclk = ~aclk;

    uart_command_line_matcher_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cmdm_reply_checker reply_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .replies_due (replies_due)
    );

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 30);
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_byte(line_q[i]);
        send_byte(CH_LF);
        line_q.delete();
    endtask

    task automatic push_text(input string s, input bit mix_case);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (mix_case && ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
            line_q.push_back(ch);
        end
    endtask

    task automatic push_digits(input int count);
        repeat (count) line_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_text_line(input string s, input bit with_cr);
        push_text(s, 1'b0);
        if (with_cr) line_q.push_back(CH_CR);
        send_line();
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_LF);
        return b;
    endfunction

    task automatic make_random_line();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            push_text(command_word[$urandom_range(0, NUM_EXACT - 1)], $urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                6: ;
                7: begin
                    line_q.push_back(CH_CR);
                    line_q.push_back(noise_byte());
                end
                8: begin
                    line_q[$urandom_range(0, line_q.size() - 1)] = noise_byte();
                    line_q.push_back(CH_CR);
                end
                9: begin
                    void'(line_q.pop_back());
                    line_q.push_back(CH_CR);
                end
                default: line_q.push_back(CH_CR);
            endcase
        end else if (kind < 80) begin
            push_text("stm servo=", $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) line_q[$urandom_range(0, 9)] = noise_byte();
            case ($urandom_range(0, 3))
                1: line_q.push_back("-");
                2: line_q.push_back("+");
                default: ;
            endcase
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 5);
            push_digits(n);
            if ($urandom_range(0, 1)) begin
                line_q.push_back(".");
                push_digits($urandom_range(0, 6));
            end
            // Sometimes a second point or a stray character stops the number early.
            if ($urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 1)) line_q.push_back(".");
                else line_q.push_back(noise_byte());
                push_digits($urandom_range(0, 3));
            end
            if ($urandom_range(0, 9) != 0) line_q.push_back(CH_CR);
            if ($urandom_range(0, 4) == 0) line_q.push_back(noise_byte());
        end else if (kind < 90) begin
            repeat ($urandom_range(0, 16)) line_q.push_back(noise_byte());
            if ($urandom_range(0, 1)) line_q.push_back(CH_CR);
        end else begin
            // A command cut short before its carriage return.
            if (kind < 95) push_text("stm servo=", 1'b0);
            else push_text(command_word[$urandom_range(0, NUM_EXACT - 1)], 1'b0);
            n = $urandom_range(0, line_q.size() - 1);
            while (line_q.size() > n) void'(line_q.pop_back());
            line_q.push_back(CH_CR);
        end
    endtask

    initial begin
        int random_start;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_text_line("stm --version", 1'b1);
        send_text_line("stm led --on", 1'b1);
        send_text_line("STM LED --OFF", 1'b1);
        send_text_line("stm get --led", 1'b1);
        send_text_line("Stm --Servo", 1'b1);
        send_text_line("stm servo=-12.5", 1'b1);
        send_text_line("stm servo=+007", 1'b1);
        send_text_line("stm servo=4294967295", 1'b1);
        send_text_line("stm servo=4294967296", 1'b1);
        send_text_line("stm servo=99999999999999.25", 1'b1);
        send_text_line("stm servo=", 1'b1);
        send_text_line("stm servo=-", 1'b1);
        send_text_line("stm servo=.5", 1'b1);
        send_text_line("stm servo=1.2.3", 1'b1);
        send_text_line("stm --version", 1'b0);
        send_text_line("stm servo=42", 1'b0);
        send_text_line("", 1'b0);
        // Argument text after the carriage return is ignored, but not for exact commands.
        push_text("stm servo=12abc", 1'b0);
        line_q.push_back(CH_CR);
        push_text("zz", 1'b0);
        send_line();
        send_text_line("stm --version", 1'b1);
        line_q.push_back(8'h00);
        send_text_line("x", 1'b1);
        line_q = '{8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_CR};
        send_line();
        // Longest line that still counts: the line feed lands at position MAX_LINE - 1.
        push_text("stm servo=1.", 1'b0);
        push_digits(MAX_LINE - 14);
        line_q.push_back(CH_CR);
        send_line();
        // A longer line goes over the limit; the bytes past it are ignored.
        push_text("stm servo=1.", 1'b0);
        push_digits(MAX_LINE - 10);
        line_q.push_back(CH_CR);
        send_line();

        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_BYTES) begin
            steady = (bytes_sent >= random_start + 100) && (bytes_sent < random_start + 250);
            make_random_line();
            send_line();
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        wait (replies_due == 0);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
